// ----- rtl/lmrs_pkg.sv -----
// Shared constants, types and the row decoder function for the LED matrix
// row-scan refresh unit. No dependencies.
`timescale 1ns / 1ps

package lmrs_pkg;

    localparam int ROW_COUNT     = 25;
    localparam int BYTES_PER_ROW = 4;
    localparam int STORE_DEPTH   = 100;

    localparam int ROW_W   = 5;
    localparam int INDEX_W = 7;
    localparam int DATA_W  = 8;
    localparam int FRAME_W = 32;
    localparam int TIMER_W = 8;

    localparam int MEM_AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int COL_W  = (BYTES_PER_ROW > 1) ? $clog2(BYTES_PER_ROW) : 1;
    localparam int RD_AW  = ROW_W + COL_W;
    localparam int LEFT_W = $clog2(BYTES_PER_ROW + 1);

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [TIMER_W-1:0] RELOAD_RESET = 8'd246;
    localparam logic [TIMER_W-1:0] TIMER_MAX    = 8'hFF;

    typedef enum logic {
        REQ_WRITE = 1'b0,
        REQ_TICK  = 1'b1
    } req_t;

    typedef enum logic {
        KIND_SERIAL = 1'b0,
        KIND_STROBE = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t               result_kind;
        logic [DATA_W-1:0]   column_byte;
        logic [DATA_W-1:0]   row_pattern;
        logic [FRAME_W-1:0]  frame_count;
        logic                last;
    } item_t;

    typedef struct packed {
        logic  en;
        item_t item;
    } push_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             full;
    } fifo_stat_t;

    // Rows 0..14 select on the low nibble, rows 15..29 on the high nibble,
    // and anything above that selects no row at all.
    function automatic logic [DATA_W-1:0] row_select(input logic [ROW_W-1:0] r);
        logic [DATA_W-1:0] rw;
        rw = DATA_W'(r);
        if (rw < 8'd15)
        begin
            return rw + 8'b00000001;
        end
        else if (rw < 8'd30)
        begin
            return DATA_W'((rw - 8'd14) << 4);
        end
        else
        begin
            return 8'b00000000;
        end
    endfunction

endpackage

// ----- rtl/lmrs_frame_store.sv -----
// Frame store: single-port write, single-port read synchronous memory with
// per-entry valid flags so that reset reads as zero. Uses lmrs_pkg.
`timescale 1ns / 1ps

module lmrs_frame_store (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [lmrs_pkg::INDEX_W-1:0] wr_addr,
    input  logic [lmrs_pkg::DATA_W-1:0]  wr_data,
    input  logic                         rd_en,
    input  logic [lmrs_pkg::RD_AW-1:0]   rd_addr,
    output logic [lmrs_pkg::DATA_W-1:0]  rd_data
);
    import lmrs_pkg::*;

    logic [DATA_W-1:0]      mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] valid_reg;
    logic [DATA_W-1:0]      data_reg;
    logic                   hit_reg;
    logic                   wr_in;
    logic                   rd_in;
    logic [MEM_AW-1:0]      wr_idx;
    logic [MEM_AW-1:0]      rd_idx;

    assign wr_in  = 32'(wr_addr) < 32'(STORE_DEPTH);
    assign rd_in  = 32'(rd_addr) < 32'(STORE_DEPTH);
    assign wr_idx = MEM_AW'(wr_addr);
    assign rd_idx = MEM_AW'(rd_addr);

    // Only one item enters per cycle, so a read and a write of the same
    // entry never fall in the same cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en && wr_in)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            data_reg <= mem[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en && wr_in)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (rd_en)
            begin
                hit_reg <= rd_in && valid_reg[rd_idx];
            end
        end
    end

    assign rd_data = hit_reg ? data_reg : '0;

endmodule

// ----- rtl/lmrs_out_fifo.sv -----
// Output queue for result items, decoupling the scan sequencer from the
// downstream stall. Uses lmrs_pkg.
`timescale 1ns / 1ps

module lmrs_out_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lmrs_pkg::push_t      push,
    input  logic                 out_stall,
    output logic                 out_valid,
    output lmrs_pkg::item_t      out_item,
    output lmrs_pkg::fifo_stat_t stat
);
    import lmrs_pkg::*;

    item_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               pop;

    assign out_valid  = count_reg != '0;
    assign pop        = out_valid && !out_stall;
    assign out_item   = mem_reg[rd_ptr_reg];
    assign stat.count = count_reg;
    assign stat.full  = count_reg == CNT_W'(FIFO_DEPTH);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.en)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push.en && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push.en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.en)
        begin
            mem_reg[wr_ptr_reg] <= push.item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/lmrs_scan_ctrl.sv -----
// Scan sequencer: reload timer, row and frame counters, and the read
// sequence over one row of the frame store. Uses lmrs_pkg.
`timescale 1ns / 1ps

module lmrs_scan_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         req_type,
    input  logic                         reload_we,
    input  logic [lmrs_pkg::TIMER_W-1:0] reload_value,
    input  lmrs_pkg::fifo_stat_t         fifo_stat,
    input  logic [lmrs_pkg::DATA_W-1:0]  rd_data,
    output logic                         in_stall,
    output logic                         rd_en,
    output logic [lmrs_pkg::RD_AW-1:0]   rd_addr,
    output lmrs_pkg::push_t              push,
    output logic                         busy
);
    import lmrs_pkg::*;

    logic [TIMER_W-1:0] reload_reg, reload_next;
    logic [TIMER_W-1:0] timer_reg, timer_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [FRAME_W-1:0] frames_reg, frames_next;
    logic               busy_reg, busy_next;
    logic [LEFT_W-1:0]  left_reg, left_next;
    logic               pend_reg, pend_next;
    logic [RD_AW-1:0]   addr_reg, addr_next;
    logic [DATA_W-1:0]  pattern_reg, pattern_next;

    logic               in_fire;
    logic               tick_fire;
    logic               start;
    logic               issue;
    logic               strobe_fire;
    logic               room;
    logic [ROW_W:0]     row_inc;
    logic [RD_AW-1:0]   first_addr;

    assign strobe_fire = busy_reg && (left_reg == '0) && !pend_reg && !fifo_stat.full;
    // Keep space for the strobe of the row in flight and the first byte of the next.
    assign in_stall    = (busy_reg && !strobe_fire)
                       || (fifo_stat.count >= CNT_W'(FIFO_DEPTH - 1));
    assign in_fire     = in_valid && !in_stall;
    assign tick_fire   = in_fire && (req_type == REQ_TICK);
    assign start       = tick_fire && (timer_reg == TIMER_MAX);
    assign room        = ({1'b0, fifo_stat.count} + (CNT_W + 1)'(pend_reg))
                       < (CNT_W + 1)'(FIFO_DEPTH);
    assign issue       = busy_reg && (left_reg != '0) && room;
    assign row_inc     = {1'b0, row_reg} + 1'b1;
    assign first_addr  = RD_AW'(RD_AW'(row_reg) * RD_AW'(BYTES_PER_ROW))
                       + RD_AW'(BYTES_PER_ROW - 1);

    assign rd_en   = start || issue;
    assign rd_addr = start ? first_addr : addr_reg;
    assign busy    = busy_reg;

    always_comb
    begin
        push.en                = pend_reg || strobe_fire;
        push.item.result_kind  = pend_reg ? KIND_SERIAL : KIND_STROBE;
        push.item.column_byte  = pend_reg ? rd_data : '0;
        push.item.row_pattern  = pend_reg ? '0 : pattern_reg;
        push.item.frame_count  = pend_reg ? '0 : frames_reg;
        push.item.last         = !pend_reg;
    end

    always_comb
    begin
        reload_next  = reload_reg;
        timer_next   = timer_reg;
        row_next     = row_reg;
        frames_next  = frames_reg;
        busy_next    = busy_reg;
        left_next    = left_reg;
        addr_next    = addr_reg;
        pattern_next = pattern_reg;
        pend_next    = rd_en;

        if (reload_we)
        begin
            reload_next = reload_value;
        end

        if (tick_fire)
        begin
            if (timer_reg == TIMER_MAX)
            begin
                timer_next = reload_reg;
            end
            else
            begin
                timer_next = timer_reg + 1'b1;
            end
        end

        if (strobe_fire)
        begin
            busy_next = 1'b0;
        end

        if (start)
        begin
            busy_next    = 1'b1;
            pattern_next = row_select(row_reg);
            left_next    = LEFT_W'(BYTES_PER_ROW - 1);
            addr_next    = first_addr - 1'b1;
            if (row_inc >= (ROW_W + 1)'(ROW_COUNT))
            begin
                row_next    = '0;
                frames_next = frames_reg + 1'b1;
            end
            else
            begin
                row_next = row_inc[ROW_W-1:0];
            end
        end
        else if (issue)
        begin
            left_next = left_reg - 1'b1;
            addr_next = addr_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg    <= addr_next;
        pattern_reg <= pattern_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reload_reg <= RELOAD_RESET;
            timer_reg  <= RELOAD_RESET;
            row_reg    <= '0;
            frames_reg <= '0;
            busy_reg   <= 1'b0;
            left_reg   <= '0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            reload_reg <= reload_next;
            timer_reg  <= timer_next;
            row_reg    <= row_next;
            frames_reg <= frames_next;
            busy_reg   <= busy_next;
            left_reg   <= left_next;
            pend_reg   <= pend_next;
        end
    end

endmodule

// ----- rtl/led_matrix_row_scan_refresh_unit.sv -----
// Row-scan refresh unit for a multiplexed LED matrix.
// Order: a write lands in the frame store at its accept edge; an overflow tick's column
// bytes pass the read register and output queue, strobe last. Throughput: one write or
// plain tick per cycle unless stalled; an overflow tick stalls input until its strobe,
// as the single read port gives one byte per cycle when the output queue has room.
// Reset: frame store reads as zero through per-entry valid flags, no clearing pass;
// timer and reload value start at 246, row and frame count at zero.
`timescale 1ns / 1ps

module led_matrix_row_scan_refresh_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          req_type,
    input  logic [lmrs_pkg::INDEX_W-1:0]  byte_index,
    input  logic [lmrs_pkg::DATA_W-1:0]   byte_value,
    input  logic                          reload_we,
    input  logic [lmrs_pkg::TIMER_W-1:0]  reload_value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          result_kind,
    output logic [lmrs_pkg::DATA_W-1:0]   column_byte,
    output logic [lmrs_pkg::DATA_W-1:0]   row_pattern,
    output logic [lmrs_pkg::FRAME_W-1:0]  frame_count,
    output logic                          last
);
    import lmrs_pkg::*;

    logic              wr_en;
    logic              rd_en;
    logic [RD_AW-1:0]  rd_addr;
    logic [DATA_W-1:0] rd_data;
    push_t             push;
    fifo_stat_t        fifo_stat;
    item_t             out_item;
    logic              busy;

    assign wr_en = in_valid && !in_stall && (req_type == REQ_WRITE);

    lmrs_frame_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (byte_index),
        .wr_data (byte_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    lmrs_scan_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .req_type     (req_type),
        .reload_we    (reload_we),
        .reload_value (reload_value),
        .fifo_stat    (fifo_stat),
        .rd_data      (rd_data),
        .in_stall     (in_stall),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .push         (push),
        .busy         (busy)
    );

    lmrs_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_item  (out_item),
        .stat      (fifo_stat)
    );

    assign result_kind = out_item.result_kind;
    assign column_byte = out_item.column_byte;
    assign row_pattern = out_item.row_pattern;
    assign frame_count = out_item.frame_count;
    assign last        = out_item.last;

`ifndef SYNTHESIS
    // The queue never holds more than its depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        fifo_stat.count <= CNT_W'(FIFO_DEPTH))
        else $error("output queue count exceeds its depth");

    // Read scheduling guarantees room, so nothing is pushed into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        fifo_stat.full |-> !push.en)
        else $error("result pushed into a full output queue");

    // A row scan only starts from an accepted tick item.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(in_valid && !in_stall && req_type))
        else $error("row scan started without an accepted tick");
`endif

endmodule

// ----- bench/tb_led_matrix_row_scan_refresh_unit.sv -----
// Self-checking testbench for the LED matrix row-scan refresh unit.
// Depends on lmrs_pkg and led_matrix_row_scan_refresh_unit; a directed table and random
// phases over several reload settings are checked against a built-in refresh predictor.
`timescale 1ns / 1ps

module tb_led_matrix_row_scan_refresh_unit;

    import lmrs_pkg::*;

    typedef struct {
        req_t                req;
        logic [INDEX_W-1:0]  idx;
        logic [DATA_W-1:0]   val;
        logic                typed;
        logic [DATA_W-1:0]   pat;
        logic [FRAME_W-1:0]  frames;
    } scan_step_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  req_type;
    logic [INDEX_W-1:0]    byte_index;
    logic [DATA_W-1:0]     byte_value;
    logic                  reload_we;
    logic [TIMER_W-1:0]    reload_value;
    logic                  out_valid;
    logic                  out_stall;
    logic                  result_kind;
    logic [DATA_W-1:0]     column_byte;
    logic [DATA_W-1:0]     row_pattern;
    logic [FRAME_W-1:0]    frame_count;
    logic                  last;

    // Predictor state for the refresh engine.
    logic [DATA_W-1:0]     matrix_store [0:STORE_DEPTH-1];
    logic [ROW_W-1:0]      scan_row;
    logic [TIMER_W-1:0]    tick_timer;
    logic [FRAME_W-1:0]    frames_seen;
    logic [TIMER_W-1:0]    reload_cfg;

    item_t                 pending_beats [$];
    scan_step_t            steps [0:19];

    int                    errors;
    int                    writes_sent;
    int                    ticks_sent;
    int                    beats_seen;
    int                    strobes_seen;
    int                    reload_writes;
    bit                    no_idle;

    led_matrix_row_scan_refresh_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .byte_index   (byte_index),
        .byte_value   (byte_value),
        .reload_we    (reload_we),
        .reload_value (reload_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_kind  (result_kind),
        .column_byte  (column_byte),
        .row_pattern  (row_pattern),
        .frame_count  (frame_count),
        .last         (last)
    );

    always #5 clk = ~clk;

    initial
    begin
        #5000000;
        $display("FAILURE");
        $finish;
    end

    task automatic report(input string field, input logic [31:0] got,
                          input logic [31:0] want);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, field, got, want);
        errors++;
    endtask

    function automatic logic [DATA_W-1:0] row_decode(input logic [ROW_W-1:0] r);
        if (r < 15)
        begin
            return DATA_W'(r) + 8'b00000001;
        end
        else if (r < 30)
        begin
            return DATA_W'((r - 14) << 4);
        end
        return 8'b00000000;
    endfunction

    // Updates the predicted state for one accepted item and queues the column bytes
    // and strobe that an overflow tick produces. A typed strobe replaces the computed one.
    task automatic predict_refresh(input req_t req, input logic [INDEX_W-1:0] idx,
                                   input logic [DATA_W-1:0] val, input logic typed,
                                   input logic [DATA_W-1:0] pat,
                                   input logic [FRAME_W-1:0] frames);
        item_t       beat;
        int          addr;
        logic [ROW_W-1:0] row;
        if (req == REQ_WRITE)
        begin
            if (idx < STORE_DEPTH)
            begin
                matrix_store[idx] = val;
            end
            return;
        end
        if (tick_timer != TIMER_MAX)
        begin
            tick_timer = tick_timer + 1'b1;
            return;
        end
        tick_timer = reload_cfg;
        row = scan_row;
        for (int k = BYTES_PER_ROW - 1; k >= 0; k--)
        begin
            addr = int'(row) * BYTES_PER_ROW + k;
            beat = '0;
            beat.result_kind = KIND_SERIAL;
            beat.column_byte = (addr < STORE_DEPTH) ? matrix_store[addr] : 8'h00;
            pending_beats.push_back(beat);
        end
        if (int'(row) + 1 >= ROW_COUNT)
        begin
            scan_row = '0;
            frames_seen = frames_seen + 1;
        end
        else
        begin
            scan_row = row + 1'b1;
        end
        beat = '0;
        beat.result_kind = KIND_STROBE;
        beat.row_pattern = typed ? pat : row_decode(row);
        beat.frame_count = typed ? frames : frames_seen;
        beat.last = 1'b1;
        pending_beats.push_back(beat);
    endtask

    task automatic send_item(input req_t req, input logic [INDEX_W-1:0] idx,
                             input logic [DATA_W-1:0] val, input logic typed,
                             input logic [DATA_W-1:0] pat,
                             input logic [FRAME_W-1:0] frames);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 12);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid = 1'b0;
        end
        @(negedge clk);
        req_type = req;
        byte_index = idx;
        byte_value = val;
        in_valid = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        if (req == REQ_WRITE)
        begin
            writes_sent++;
        end
        else
        begin
            ticks_sent++;
        end
        predict_refresh(req, idx, val, typed, pat, frames);
    endtask

    // Holds the sender off until every queued result has been taken, then lets the
    // block settle, since writes and plain ticks give no result.
    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_beats.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic load_reload(input logic [TIMER_W-1:0] v);
        @(negedge clk);
        reload_we = 1'b1;
        reload_value = v;
        @(negedge clk);
        reload_we = 1'b0;
        reload_cfg = v;
        reload_writes++;
    endtask

    task automatic run_random(input int count, input int tick_pct);
        req_t req;
        for (int n = 0; n < count; n++)
        begin
            req = ($urandom_range(0, 99) < tick_pct) ? REQ_TICK : REQ_WRITE;
            send_item(req, INDEX_W'($urandom_range(0, 127)), DATA_W'($urandom), 1'b0,
                      8'h00, 32'd0);
        end
        drain_results();
    endtask

    // Result side: holds out_stall high for a random spell before each item unless no_idle is set, then checks it.
    initial
    begin
        item_t want;
        int    hold;
        @(posedge rst_n);
        forever
        begin
            hold = no_idle ? 0 : $urandom_range(0, 12);
            repeat (hold)
            begin
                @(negedge clk);
                out_stall = 1'b1;
            end
            @(negedge clk);
            out_stall = 1'b0;
            do
            begin
                @(posedge clk);
            end
            while (!out_valid);
            beats_seen++;
            if (pending_beats.size() == 0)
            begin
                report("unexpected result", 32'(column_byte), 32'd0);
            end
            else
            begin
                want = pending_beats.pop_front();
                if (want.result_kind == KIND_STROBE)
                begin
                    strobes_seen++;
                end
                if (result_kind !== want.result_kind)
                    report("result_kind", 32'(result_kind), 32'(want.result_kind));
                if (column_byte !== want.column_byte)
                    report("column_byte", 32'(column_byte), 32'(want.column_byte));
                if (row_pattern !== want.row_pattern)
                    report("row_pattern", 32'(row_pattern), 32'(want.row_pattern));
                if (frame_count !== want.frame_count)
                    report("frame_count", frame_count, want.frame_count);
                if (last !== want.last)
                    report("last", 32'(last), 32'(want.last));
            end
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = 1'b0;
        byte_index = '0;
        byte_value = '0;
        reload_we = 1'b0;
        reload_value = '0;
        out_stall = 1'b0;
        errors = 0;
        writes_sent = 0;
        ticks_sent = 0;
        beats_seen = 0;
        strobes_seen = 0;
        reload_writes = 0;
        no_idle = 1'b0;

        for (int a = 0; a < STORE_DEPTH; a++)
        begin
            matrix_store[a] = 8'h00;
        end
        scan_row = '0;
        tick_timer = RELOAD_RESET;
        frames_seen = '0;
        reload_cfg = RELOAD_RESET;

        // Out-of-range writes must leave the store alone; the tenth tick from the
        // reset value overflows and refreshes row 0 as the first strobe of frame 0.
        steps = '{
            '{REQ_WRITE, 7'd0,   8'hFF, 1'b0, 8'h00, 32'd0},
            '{REQ_WRITE, 7'd3,   8'h01, 1'b0, 8'h00, 32'd0},
            '{REQ_WRITE, 7'd99,  8'h80, 1'b0, 8'h00, 32'd0},
            '{REQ_WRITE, 7'd100, 8'h55, 1'b0, 8'h00, 32'd0},
            '{REQ_WRITE, 7'd127, 8'hAA, 1'b0, 8'h00, 32'd0},
            '{REQ_WRITE, 7'd98,  8'h7F, 1'b0, 8'h00, 32'd0},
            '{REQ_TICK,  7'd0,   8'h00, 1'b0, 8'h00, 32'd0},
            '{REQ_TICK,  7'd127, 8'hFF, 1'b0, 8'h00, 32'd0},
            '{REQ_TICK,  7'd0,   8'h00, 1'b0, 8'h00, 32'd0},
            '{REQ_TICK,  7'd0,   8'h00, 1'b0, 8'h00, 32'd0},
            '{REQ_TICK,  7'd0,   8'h00, 1'b0, 8'h00, 32'd0},
            '{REQ_TICK,  7'd0,   8'h00, 1'b0, 8'h00, 32'd0},
            '{REQ_TICK,  7'd0,   8'h00, 1'b0, 8'h00, 32'd0},
            '{REQ_TICK,  7'd0,   8'h00, 1'b0, 8'h00, 32'd0},
            '{REQ_TICK,  7'd0,   8'h00, 1'b0, 8'h00, 32'd0},
            '{REQ_TICK,  7'd0,   8'h00, 1'b1, 8'b00000001, 32'd0},
            '{REQ_WRITE, 7'd4,   8'h0F, 1'b0, 8'h00, 32'd0},
            '{REQ_WRITE, 7'd7,   8'hF0, 1'b0, 8'h00, 32'd0},
            '{REQ_WRITE, 7'd50,  8'hA0, 1'b0, 8'h00, 32'd0},
            '{REQ_WRITE, 7'd2,   8'h10, 1'b0, 8'h00, 32'd0}
        };

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (steps[i])
        begin
            send_item(steps[i].req, steps[i].idx, steps[i].val, steps[i].typed,
                      steps[i].pat, steps[i].frames);
        end
        drain_results();

        // Once the timer reaches the top reload value every tick overflows, so rows and frames move fast.
        load_reload(8'd255);
        run_random(25, 75);
        no_idle = 1'b1;
        run_random(20, 80);
        no_idle = 1'b0;

        load_reload(TIMER_W'($urandom_range(240, 254)));
        run_random(30, 70);
        load_reload(RELOAD_RESET);
        run_random(15, 80);

        // The timer sits at 240 or above here, so an overflow comes within these ticks
        // and loads zero, after which the remaining ticks only count up.
        load_reload(8'd0);
        run_random(20, 100);

        $display("Ran %0d writes and %0d ticks over %0d reload settings.",
                 writes_sent, ticks_sent, reload_writes + 1);
        $display("Checked %0d results, %0d of them row strobes, through frame %0d.",
                 beats_seen, strobes_seen, frames_seen);
        if (errors == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/lmrs_pkg.sv
rtl/lmrs_frame_store.sv
rtl/lmrs_out_fifo.sv
rtl/lmrs_scan_ctrl.sv
rtl/led_matrix_row_scan_refresh_unit.sv
bench/tb_led_matrix_row_scan_refresh_unit.sv
